// ----- hdl/tsac_pkg.sv -----
package tsac_pkg;

    // Field widths fixed by the sample, register and point formats.
    localparam int SAMPLE_W    = 13;
    localparam int SUM_W       = 21;
    localparam int COUNT_W     = 8;
    localparam int ATTEMPT_W   = 9;
    localparam int SIZE_W      = 12;
    localparam int POINT_W     = 26;

    // Serial divider: dividend and divisor widths.
    localparam int DVD_W       = 25;
    localparam int DVS_W       = 13;

    // Queue between the accumulator and the calibration engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef enum logic [2:0] {
        CFG_PRECISION     = 3'd0,
        CFG_SCREEN_WIDTH  = 3'd1,
        CFG_SCREEN_HEIGHT = 3'd2,
        CFG_ROTATION      = 3'd3,
        CFG_CAL_LEFT      = 3'd4,
        CFG_CAL_TOP       = 3'd5,
        CFG_CAL_RIGHT     = 3'd6,
        CFG_CAL_BOTTOM    = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rotation_t;

    // One finished reading handed from the accumulator to the engine.
    typedef struct packed {
        logic [SUM_W-1:0]   x_sum;
        logic [SUM_W-1:0]   y_sum;
        logic [COUNT_W-1:0] count;
        logic               touched;
    } job_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  precision;
        logic [SIZE_W-1:0]   screen_width;
        logic [SIZE_W-1:0]   screen_height;
        rotation_t           rotation;
        logic [SAMPLE_W-1:0] cal_left;
        logic [SAMPLE_W-1:0] cal_top;
        logic [SAMPLE_W-1:0] cal_right;
        logic [SAMPLE_W-1:0] cal_bottom;
    } cfg_t;

    // Queue handshake towards the engine.
    typedef struct packed {
        logic not_full;
        logic not_empty;
    } q_status_t;

endpackage

// ----- hdl/tsac_front.sv -----
module tsac_front
    import tsac_pkg::*;
#(
    parameter int MAX_PRECISION = 255
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample_x,
    input  logic [SAMPLE_W-1:0] sample_y,
    input  logic [COUNT_W-1:0]  precision,
    input  q_status_t           q_status,
    output logic                q_push,
    output job_t                q_job
);

    localparam logic [9:0] MaxPrec = MAX_PRECISION[9:0];

    logic [SUM_W-1:0]     x_sum_reg, x_sum_next;
    logic [SUM_W-1:0]     y_sum_reg, y_sum_next;
    logic [COUNT_W-1:0]   valid_count_reg, valid_count_next;
    logic [ATTEMPT_W-1:0] attempt_count_reg, attempt_count_next;

    logic [COUNT_W-1:0]   prec_eff;
    logic [ATTEMPT_W-1:0] attempt_limit;
    logic                 accept;
    logic                 pair_ok;
    logic                 reading_done;

    assign prec_eff      = ({2'b00, precision} > MaxPrec) ? MaxPrec[COUNT_W-1:0] : precision;
    assign attempt_limit = {prec_eff, 1'b0};
    assign in_ready      = q_status.not_full;
    assign accept        = in_valid & q_status.not_full;
    assign pair_ok       = (sample_x != '0) && (sample_y != '0);

    always_comb
    begin
        attempt_count_next = attempt_count_reg + 1'b1;
        x_sum_next         = x_sum_reg;
        y_sum_next         = y_sum_reg;
        valid_count_next   = valid_count_reg;
        if (pair_ok)
        begin
            x_sum_next       = x_sum_reg + SUM_W'(sample_x);
            y_sum_next       = y_sum_reg + SUM_W'(sample_y);
            valid_count_next = valid_count_reg + 1'b1;
        end
        reading_done = (prec_eff == '0) ||
                       !((valid_count_next < prec_eff) && (attempt_count_next < attempt_limit));
    end

    assign q_push        = accept && reading_done;
    assign q_job.x_sum   = x_sum_next;
    assign q_job.y_sum   = y_sum_next;
    assign q_job.count   = valid_count_next;
    assign q_job.touched = (prec_eff != '0) && (valid_count_next != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_sum_reg         <= '0;
            y_sum_reg         <= '0;
            valid_count_reg   <= '0;
            attempt_count_reg <= '0;
        end
        else if (accept)
        begin
            if (reading_done)
            begin
                x_sum_reg         <= '0;
                y_sum_reg         <= '0;
                valid_count_reg   <= '0;
                attempt_count_reg <= '0;
            end
            else
            begin
                x_sum_reg         <= x_sum_next;
                y_sum_reg         <= y_sum_next;
                valid_count_reg   <= valid_count_next;
                attempt_count_reg <= attempt_count_next;
            end
        end
    end

endmodule

// ----- hdl/tsac_queue.sv -----
module tsac_queue
    import tsac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head_job,
    output q_status_t status
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   fill_reg;
    logic                do_push;
    logic                do_pop;

    assign status.not_full  = (fill_reg < (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign status.not_empty = (fill_reg != '0);
    assign do_push          = push && status.not_full;
    assign do_pop           = pop && status.not_empty;
    assign head_job         = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/tsac_div.sv -----
module tsac_div
    import tsac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int StepW = $clog2(DVD_W);

    logic [DVD_W-1:0] dq_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [StepW-1:0] step_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;
    logic [DVS_W-1:0] rem_next;

    // Restoring division, one quotient bit per cycle; quotient bits shift in
    // behind the dividend bits as they are consumed.
    assign trial    = {rem_reg, dq_reg[DVD_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign fits     = (trial >= {1'b0, dvs_reg});
    assign rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    assign done     = done_reg;
    assign quotient = dq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dq_reg   <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dq_reg   <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                step_reg <= StepW'(DVD_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                dq_reg   <= {dq_reg[DVD_W-2:0], fits};
                rem_reg  <= rem_next;
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hdl/tsac_back.sv -----
module tsac_back
    import tsac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  q_status_t          q_status,
    input  job_t               q_job,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [POINT_W-1:0] point_x,
    output logic [POINT_W-1:0] point_y,
    output logic               touched
);

    localparam int ProdW = SAMPLE_W + SIZE_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_MUL,
        S_SCALE,
        S_EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic signed [ProdW-1:0]   prod_x_reg, prod_x_next;
    logic signed [ProdW-1:0]   prod_y_reg, prod_y_next;
    logic [POINT_W-1:0]        dx_reg, dx_next;
    logic [POINT_W-1:0]        dy_reg, dy_next;
    logic                      job_touched_reg, job_touched_next;
    logic                      out_valid_reg, out_valid_next;
    logic [POINT_W-1:0]        point_x_reg, point_x_next;
    logic [POINT_W-1:0]        point_y_reg, point_y_next;
    logic                      touched_reg, touched_next;

    logic signed [SAMPLE_W:0]  span_x, span_y;
    logic [SAMPLE_W:0]         span_x_abs, span_y_abs;
    logic signed [SAMPLE_W:0]  off_x, off_y;
    logic signed [ProdW-1:0]   prod_x, prod_y;
    logic [ProdW-1:0]          mag_x, mag_y;
    logic                      neg_x, neg_y;
    logic [POINT_W-1:0]        quot_x_ext, quot_y_ext;
    logic [POINT_W-1:0]        scaled_x, scaled_y;
    logic [POINT_W-1:0]        dw_ext, dh_ext;
    logic [POINT_W-1:0]        rot_x, rot_y;

    logic                      avg_start, scale_start;
    logic                      div_x_start, div_y_start;
    logic [DVD_W-1:0]          div_x_dividend, div_y_dividend;
    logic [DVS_W-1:0]          div_x_divisor, div_y_divisor;
    logic                      div_x_done, div_y_done;
    logic [DVD_W-1:0]          div_x_quot, div_y_quot;

    // Calibration spans and their magnitudes.
    assign span_x     = $signed({1'b0, cfg.cal_right}) - $signed({1'b0, cfg.cal_left});
    assign span_y     = $signed({1'b0, cfg.cal_bottom}) - $signed({1'b0, cfg.cal_top});
    assign span_x_abs = span_x[SAMPLE_W] ? -span_x : span_x;
    assign span_y_abs = span_y[SAMPLE_W] ? -span_y : span_y;

    // Averages are offset by the calibration origin and scaled to pixels.
    assign off_x  = $signed({1'b0, div_x_quot[SAMPLE_W-1:0]}) - $signed({1'b0, cfg.cal_left});
    assign off_y  = $signed({1'b0, div_y_quot[SAMPLE_W-1:0]}) - $signed({1'b0, cfg.cal_top});
    assign prod_x = off_x * $signed({1'b0, cfg.screen_width});
    assign prod_y = off_y * $signed({1'b0, cfg.screen_height});

    assign mag_x  = prod_x_reg[ProdW-1] ? -prod_x_reg : prod_x_reg;
    assign mag_y  = prod_y_reg[ProdW-1] ? -prod_y_reg : prod_y_reg;
    assign neg_x  = prod_x_reg[ProdW-1] ^ span_x[SAMPLE_W];
    assign neg_y  = prod_y_reg[ProdW-1] ^ span_y[SAMPLE_W];

    assign quot_x_ext = {1'b0, div_x_quot};
    assign quot_y_ext = {1'b0, div_y_quot};
    assign scaled_x   = (span_x == '0) ? '0 : (neg_x ? -quot_x_ext : quot_x_ext);
    assign scaled_y   = (span_y == '0) ? '0 : (neg_y ? -quot_y_ext : quot_y_ext);

    assign dw_ext = POINT_W'(cfg.screen_width);
    assign dh_ext = POINT_W'(cfg.screen_height);

    always_comb
    begin
        case (cfg.rotation)
            ROT_0:
            begin
                rot_x = dx_reg;
                rot_y = dy_reg;
            end
            ROT_90:
            begin
                rot_x = dy_reg;
                rot_y = dw_ext - dx_reg;
            end
            ROT_180:
            begin
                rot_x = dw_ext - dx_reg;
                rot_y = dh_ext - dy_reg;
            end
            default:
            begin
                rot_x = dh_ext - dy_reg;
                rot_y = dx_reg;
            end
        endcase
    end

    // Both lanes share one sequence: averaging division, then scaling division.
    assign q_pop       = (state_reg == S_IDLE) && q_status.not_empty;
    assign avg_start   = q_pop && q_job.touched;
    assign scale_start = (state_reg == S_MUL);
    assign div_x_start = avg_start | scale_start;
    assign div_y_start = avg_start | scale_start;

    assign div_x_dividend = avg_start ? DVD_W'(q_job.x_sum) : mag_x[DVD_W-1:0];
    assign div_y_dividend = avg_start ? DVD_W'(q_job.y_sum) : mag_y[DVD_W-1:0];
    assign div_x_divisor  = avg_start ? DVS_W'(q_job.count) : span_x_abs[DVS_W-1:0];
    assign div_y_divisor  = avg_start ? DVS_W'(q_job.count) : span_y_abs[DVS_W-1:0];

    tsac_div u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_x_start),
        .dividend (div_x_dividend),
        .divisor  (div_x_divisor),
        .done     (div_x_done),
        .quotient (div_x_quot)
    );

    tsac_div u_div_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_y_start),
        .dividend (div_y_dividend),
        .divisor  (div_y_divisor),
        .done     (div_y_done),
        .quotient (div_y_quot)
    );

    always_comb
    begin
        state_next       = state_reg;
        prod_x_next      = prod_x_reg;
        prod_y_next      = prod_y_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        job_touched_next = job_touched_reg;
        out_valid_next   = out_valid_reg;
        point_x_next     = point_x_reg;
        point_y_next     = point_y_reg;
        touched_next     = touched_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    job_touched_next = q_job.touched;
                    state_next       = q_job.touched ? S_AVG : S_EMIT;
                end
            end
            S_AVG:
            begin
                if (div_x_done)
                begin
                    prod_x_next = prod_x;
                    prod_y_next = prod_y;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                if (div_x_done)
                begin
                    dx_next    = scaled_x;
                    dy_next    = scaled_y;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    point_x_next   = job_touched_reg ? rot_x : '0;
                    point_y_next   = job_touched_reg ? rot_y : '0;
                    touched_next   = job_touched_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            prod_x_reg      <= '0;
            prod_y_reg      <= '0;
            dx_reg          <= '0;
            dy_reg          <= '0;
            job_touched_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            point_x_reg     <= '0;
            point_y_reg     <= '0;
            touched_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            prod_x_reg      <= prod_x_next;
            prod_y_reg      <= prod_y_next;
            dx_reg          <= dx_next;
            dy_reg          <= dy_next;
            job_touched_reg <= job_touched_next;
            out_valid_reg   <= out_valid_next;
            point_x_reg     <= point_x_next;
            point_y_reg     <= point_y_next;
            touched_reg     <= touched_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign touched   = touched_reg;

`ifndef NO_ASSERTIONS
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_x_done == div_y_done)
        else $error("x and y dividers out of step");

    a_untouched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !touched_reg) |-> (point_x_reg == '0 && point_y_reg == '0))
        else $error("untouched point carries non-zero coordinates");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_valid_reg && !out_ready) |=> (state_reg == S_EMIT))
        else $error("engine left emit while the output register was still full");

    a_done_only_when_working: assert property (@(posedge clk) disable iff (!rst_n)
        div_x_done |-> (state_reg == S_AVG || state_reg == S_SCALE))
        else $error("divider finished outside a division state");
`endif

endmodule

// ----- hdl/touch_sample_average_calibrate.sv -----
// Touch sample averaging and calibration.
//
// Raw touch conversion pairs arrive as requests on the s_axis channel. A pair
// with either value zero is ignored but still counts as an attempt. Once the
// programmed number of valid pairs has been collected, or twice that number of
// pairs has been seen, one point leaves on the m_axis channel: the averaged
// raw position, offset by the calibration origin, scaled to the display size
// with division truncating towards zero and rotated in steps of 90 degrees.
// tuser flags whether any valid pair went into the point; an untouched point
// is (0,0). A precision of zero turns every request into an untouched point.
//
// The accumulator takes one request per cycle while its two-entry queue has
// room. The calibration engine runs two serial dividers (x and y) one bit per
// cycle, once for the average and once for the scaling; untouched points skip
// both divisions. The engine works on one reading at a time and takes the next
// from the queue only once the previous point is in the output register.
// If the receiver stalls, the finished point waits in the output register and
// the queue fills before s_axis_tready drops. Reset clears the accumulators
// and queue and loads the register defaults. The cfg channel always accepts
// and is to be written only while no reading is in flight.
module touch_sample_average_calibrate
    import tsac_pkg::*;
#(
    parameter int MAX_PRECISION = 255
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Sample requests.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [12:0] sample_x, [25:13] sample_y, [31:26] zero

    // Calibrated points.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [25:0] point_x, [51:26] point_y, [55:52] zero
    output logic        m_axis_tuser,   // [0] touched

    // Register writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    cfg_t               cfg_reg;
    q_status_t          q_status;
    logic               q_push;
    logic               q_pop;
    job_t               push_job;
    job_t               head_job;
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;

    // Register file: every write lands at once; the index space is full.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.precision     <= COUNT_W'(10);
            cfg_reg.screen_width  <= SIZE_W'(320);
            cfg_reg.screen_height <= SIZE_W'(240);
            cfg_reg.rotation      <= ROT_0;
            cfg_reg.cal_left      <= '0;
            cfg_reg.cal_top       <= '0;
            cfg_reg.cal_right     <= '1;
            cfg_reg.cal_bottom    <= '1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PRECISION:     cfg_reg.precision     <= cfg_data[COUNT_W-1:0];
                CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[SIZE_W-1:0];
                CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[SIZE_W-1:0];
                CFG_ROTATION:      cfg_reg.rotation      <= rotation_t'(cfg_data[1:0]);
                CFG_CAL_LEFT:      cfg_reg.cal_left      <= cfg_data;
                CFG_CAL_TOP:       cfg_reg.cal_top       <= cfg_data;
                CFG_CAL_RIGHT:     cfg_reg.cal_right     <= cfg_data;
                CFG_CAL_BOTTOM:    cfg_reg.cal_bottom    <= cfg_data;
                default:           cfg_reg.precision     <= cfg_reg.precision;
            endcase
        end
    end

    // Front: accumulates pairs and hands each finished reading to the queue.
    tsac_front #(
        .MAX_PRECISION (MAX_PRECISION)
    ) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .sample_x  (s_axis_tdata[12:0]),
        .sample_y  (s_axis_tdata[25:13]),
        .precision (cfg_reg.precision),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    tsac_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Back: averages, calibrates, scales and rotates one reading at a time.
    tsac_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .point_x   (point_x),
        .point_y   (point_y),
        .touched   (m_axis_tuser)
    );

    assign m_axis_tdata = {4'b0000, point_y, point_x};

endmodule

// ----- bench/touch_point_checker.sv -----
module touch_point_checker
    import tsac_pkg::*;
#(
    parameter int PREC_CAP = 255
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [12:0] sample_x, [25:13] sample_y, [31:26] zero

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // [25:0] point_x, [51:26] point_y, [55:52] zero
    input  logic        m_axis_tuser,   // [0] touched

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,

    output int          mismatches,
    output int          points_due,
    output int          points_seen,
    output int          touched_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
        logic                      touched;
    } point_t;

    // Shadow copy of the register file.
    logic [COUNT_W-1:0]  prec_reg;
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;
    rotation_t           rot_reg;
    logic [SAMPLE_W-1:0] left_reg;
    logic [SAMPLE_W-1:0] top_reg;
    logic [SAMPLE_W-1:0] right_reg;
    logic [SAMPLE_W-1:0] bottom_reg;

    // Running sums of the reading in progress.
    logic [SUM_W-1:0]     sum_x;
    logic [SUM_W-1:0]     sum_y;
    logic [COUNT_W-1:0]   n_valid;
    logic [ATTEMPT_W-1:0] n_tried;

    point_t expected_points[$];
    int     reported;

    function automatic longint to_display(longint offset, longint size, longint span);
        if (span == 0)
            return 0;
        return (offset * size) / span;
    endfunction

    task automatic clear_reading();
        sum_x   = '0;
        sum_y   = '0;
        n_valid = '0;
        n_tried = '0;
    endtask

    task automatic push_point(longint px, longint py, logic touched);
        point_t p;
        p.x       = px[POINT_W-1:0];
        p.y       = py[POINT_W-1:0];
        p.touched = touched;
        expected_points.push_back(p);
    endtask

    task automatic store_register(logic [2:0] idx, logic [12:0] val);
        case (cfg_index_t'(idx))
            CFG_PRECISION:     prec_reg   = val[COUNT_W-1:0];
            CFG_SCREEN_WIDTH:  width_reg  = val[SIZE_W-1:0];
            CFG_SCREEN_HEIGHT: height_reg = val[SIZE_W-1:0];
            CFG_ROTATION:      rot_reg    = rotation_t'(val[1:0]);
            CFG_CAL_LEFT:      left_reg   = val;
            CFG_CAL_TOP:       top_reg    = val;
            CFG_CAL_RIGHT:     right_reg  = val;
            CFG_CAL_BOTTOM:    bottom_reg = val;
            default: ;
        endcase
    endtask

    // Adds one sample pair to the reading and, when the reading closes,
    // queues the point that the block should produce.
    task automatic accumulate_sample(logic [SAMPLE_W-1:0] sx, logic [SAMPLE_W-1:0] sy);
        int     prec;
        longint w, h, dx, dy, px, py;
        prec = prec_reg;
        if (prec > PREC_CAP)
            prec = PREC_CAP;
        if (prec == 0) begin
            clear_reading();
            push_point(0, 0, 1'b0);
            return;
        end
        n_tried = n_tried + 1'b1;
        if (sx != 0 && sy != 0) begin
            sum_x   = sum_x + SUM_W'(sx);
            sum_y   = sum_y + SUM_W'(sy);
            n_valid = n_valid + 1'b1;
        end
        if (n_valid < prec && n_tried < 2 * prec)
            return;
        if (n_valid == 0) begin
            clear_reading();
            push_point(0, 0, 1'b0);
            return;
        end
        w  = width_reg;
        h  = height_reg;
        dx = to_display(longint'(sum_x / n_valid) - longint'(left_reg), w,
                        longint'(right_reg) - longint'(left_reg));
        dy = to_display(longint'(sum_y / n_valid) - longint'(top_reg), h,
                        longint'(bottom_reg) - longint'(top_reg));
        case (rot_reg)
            ROT_0:   begin px = dx;     py = dy;     end
            ROT_90:  begin px = dy;     py = w - dx; end
            ROT_180: begin px = w - dx; py = h - dy; end
            default: begin px = h - dy; py = dx;     end
        endcase
        clear_reading();
        push_point(px, py, 1'b1);
    endtask

    task automatic check_point(logic [55:0] data, logic touched);
        point_t got, want;
        got.x       = data[POINT_W-1:0];
        got.y       = data[2*POINT_W-1:POINT_W];
        got.touched = touched;
        points_seen++;
        if (touched)
            touched_seen++;
        if (expected_points.size() == 0) begin
            mismatches++;
            if (reported < 10) begin
                reported++;
                $display("unexpected point: x=%0d y=%0d touched=%0d",
                         got.x, got.y, got.touched);
            end
            return;
        end
        want = expected_points.pop_front();
        if (got.x != want.x || got.y != want.y || got.touched != want.touched) begin
            mismatches++;
            if (reported < 10) begin
                reported++;
                $display("mismatch: expected x=%0d y=%0d t=%0d, got x=%0d y=%0d t=%0d",
                         want.x, want.y, want.touched, got.x, got.y, got.touched);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prec_reg     = 8'd10;
            width_reg    = 12'd320;
            height_reg   = 12'd240;
            rot_reg      = ROT_0;
            left_reg     = '0;
            top_reg      = '0;
            right_reg    = '1;
            bottom_reg   = '1;
            mismatches   = 0;
            points_seen  = 0;
            touched_seen = 0;
            reported     = 0;
            clear_reading();
            expected_points.delete();
        end
        else begin
            if (cfg_valid && cfg_ready)
                store_register(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                accumulate_sample(s_axis_tdata[12:0], s_axis_tdata[25:13]);
            if (m_axis_tvalid && m_axis_tready)
                check_point(m_axis_tdata, m_axis_tuser);
        end
        points_due = expected_points.size();
    end

endmodule

// ----- bench/touch_sample_average_calibrate_tb.sv -----
module touch_sample_average_calibrate_tb
    import tsac_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted request before the run is abandoned. The
    // longest legitimate quiet stretch is a drain pause plus one touched point
    // held up by the receiver, well under this figure.
    localparam int WATCHDOG_LIMIT = 5000;
    // Quiet cycles allowed after the last point, before a register write and
    // at the end, so that anything still in the engine has time to appear.
    localparam int SETTLE_CYCLES  = 100;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [12:0] sample_x, [25:13] sample_y, [31:26] zero

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // [25:0] point_x, [51:26] point_y, [55:52] zero
    logic        m_axis_tuser;         // [0] touched

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [12:0] cfg_data  = '0;

    int mismatches, points_due, points_seen, touched_seen;

    // Idling of the two sides, in percent of cycles.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int samples_sent  = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;

    touch_sample_average_calibrate uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    touch_point_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .points_due    (points_due),
        .points_seen   (points_seen),
        .touched_seen  (touched_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver decides afresh at every falling edge whether to stall.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Selects one of the four idling patterns: none, sender idle, receiver
    // stalling, and both sides idling together.
    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
    endtask

    // Offers one sample pair and returns at the falling edge after it was
    // accepted, leaving tvalid high so that back-to-back requests follow.
    task automatic send_sample(logic [12:0] sx, logic [12:0] sy);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, sy, sx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        samples_sent++;
        @(negedge clk);
    endtask

    // Stops sending and waits until every point predicted so far has arrived.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (points_due != 0)
            @(negedge clk);
    endtask

    // Makes the block idle for a register write. A sample that closes no
    // reading leaves nothing to wait for, so a fixed settling pause follows.
    task automatic drain();
        hold_until_drained();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic write_reg(cfg_index_t idx, logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_setting(int prec, int w, int h, rotation_t rot,
                                 int left, int top, int right, int bottom);
        drain();
        write_reg(CFG_PRECISION,     13'(prec));
        write_reg(CFG_SCREEN_WIDTH,  13'(w));
        write_reg(CFG_SCREEN_HEIGHT, 13'(h));
        write_reg(CFG_ROTATION,      13'(rot));
        write_reg(CFG_CAL_LEFT,      13'(left));
        write_reg(CFG_CAL_TOP,       13'(top));
        write_reg(CFG_CAL_RIGHT,     13'(right));
        write_reg(CFG_CAL_BOTTOM,    13'(bottom));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Leans towards the extremes of the raw range and towards zero, which
    // makes the pair invalid.
    function automatic logic [12:0] pick_coord();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0:       return 13'd0;
            1:       return 13'd8191;
            2:       return 13'd1;
            default: return 13'($urandom_range(1, 8191));
        endcase
    endfunction

    // Mostly valid pairs so that readings complete, with scattered invalid
    // pairs and the odd burst of them to push readings to the attempt limit.
    // Halfway through, the sender waits for every outstanding point.
    task automatic run_random(int count, int mode);
        int zero_run;
        int i;
        zero_run = 0;
        set_idling(mode);
        for (i = 0; i < count; i++) begin
            if (i == count / 2)
                hold_until_drained();
            if (zero_run == 0 && $urandom_range(0, 39) == 0)
                zero_run = $urandom_range(1, 20);
            if (zero_run > 0) begin
                zero_run--;
                if ($urandom_range(0, 1))
                    send_sample(13'd0, pick_coord());
                else
                    send_sample(pick_coord(), 13'd0);
            end
            else begin
                send_sample(pick_coord(), pick_coord());
            end
        end
    endtask

    // Fully random registers, with precision mostly small so that points
    // keep coming, and calibration spans of either sign or zero.
    task automatic random_setting();
        int r, prec;
        r = $urandom_range(0, 9);
        if (r == 0)
            prec = 0;
        else if (r <= 6)
            prec = $urandom_range(1, 8);
        else if (r <= 8)
            prec = $urandom_range(9, 40);
        else
            prec = $urandom_range(100, 255);
        apply_setting(prec, $urandom_range(1, 4095), $urandom_range(1, 4095),
                      rotation_t'($urandom_range(0, 3)),
                      $urandom_range(0, 8191), $urandom_range(0, 8191),
                      $urandom_range(0, 8191), $urandom_range(0, 8191));
    endtask

    // Any accepted request on any channel counts as progress.
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int k;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. With a precision of one every valid pair is a point
        // of its own; raw extremes and full-size scaling come first.
        set_idling(0);
        apply_setting(1, 4095, 4095, ROT_0, 0, 0, 8191, 8191);
        send_sample(13'd8191, 13'd8191);
        send_sample(13'd1, 13'd1);
        send_sample(13'd8191, 13'd1);
        send_sample(13'd1, 13'd8191);
        // Two invalid pairs hit the attempt limit: an untouched point.
        send_sample(13'd0, 13'd8191);
        send_sample(13'd8191, 13'd0);
        // An invalid pair followed by a valid one still gives a touched point.
        send_sample(13'd0, 13'd0);
        send_sample(13'd4096, 13'd2730);

        // Precision zero: every sample pair becomes an untouched point.
        apply_setting(0, 4095, 4095, ROT_0, 0, 0, 8191, 8191);
        send_sample(13'd8191, 13'd8191);
        send_sample(13'd0, 13'd0);

        // Zero span on x and a reversed span on y, rotated by 90 degrees,
        // then a reading of nothing but invalid pairs.
        apply_setting(2, 320, 240, ROT_90, 4000, 8191, 4000, 0);
        send_sample(13'd8191, 13'd8191);
        send_sample(13'd1, 13'd1);
        repeat (4)
            send_sample(13'd0, 13'd0);

        // Precision lowered in the middle of a reading: the sums are kept
        // and the next pair closes the reading with three pairs in it.
        apply_setting(4, 4095, 1, ROT_180, 100, 100, 8000, 8000);
        send_sample(13'd5000, 13'd5000);
        send_sample(13'd6000, 13'd6000);
        drain();
        write_reg(CFG_PRECISION, 13'd2);
        cfg_valid <= 1'b0;
        send_sample(13'd7000, 13'd7000);

        // Rotation by 270 degrees with a fully reversed calibration.
        apply_setting(1, 1, 4095, ROT_270, 8191, 8191, 0, 0);
        send_sample(13'd8191, 13'd8191);
        send_sample(13'd1, 13'd1);

        // Random part: fixed corner settings first, then random ones. Each
        // phase takes the next idling pattern in turn.
        apply_setting(1, 320, 240, ROT_0, 200, 300, 3900, 3800);
        run_random(150, 0);
        apply_setting(4, 4095, 1, ROT_90, 0, 0, 8191, 8191);
        run_random(150, 1);
        apply_setting(3, 1, 4095, ROT_180, 8000, 7000, 100, 50);
        run_random(150, 2);
        apply_setting(255, 4095, 4095, ROT_270, 0, 0, 1, 1);
        run_random(300, 3);
        for (k = 0; k < 5; k++) begin
            random_setting();
            run_random(150, k);
        end

        // Wind down: every predicted point must arrive, and nothing more.
        hold_until_drained();
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        $display("Run covered %0d sample requests under %0d register settings,",
                 samples_sent, settings_used);
        $display("all four rotations and idling patterns; %0d points came back, %0d touched.",
                 points_seen, touched_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
